// ===== design/rtcdc_pkg.sv =====
`default_nettype none

package rtcdc_pkg;

    localparam int TICKS_PER_SECOND_DEF = 128;

    localparam int DRIFT_W     = 16;
    localparam int CAL_W       = 15;
    localparam int TIME_W      = 6;
    localparam int MENU_W      = 8;
    localparam int OUT_DATA_W  = 32;

    localparam logic signed [DRIFT_W-1:0] DRIFT_LIMIT_POS = 16'sd999;
    localparam logic signed [DRIFT_W-1:0] DRIFT_LIMIT_NEG = -16'sd999;
    localparam logic signed [DRIFT_W-1:0] DRIFT_STEP      = 16'sd1000;
    localparam logic signed [DRIFT_W:0]   DRIFT_SAT_MAX   = 17'sd32767;
    localparam logic signed [DRIFT_W:0]   DRIFT_SAT_MIN   = -17'sd32768;

    localparam logic [TIME_W-1:0] TIME_MAX = 6'd59;

    typedef enum logic [1:0] {
        PRELOAD_NONE    = 2'd0,
        PRELOAD_RETARD  = 2'd1,
        PRELOAD_ADVANCE = 2'd2
    } t_preload;

    typedef struct packed {
        logic [MENU_W-1:0] menu_remaining;
        logic [TIME_W-1:0] minutes_now;
        logic [TIME_W-1:0] seconds_now;
        logic              hour_pulse;
        logic              minute_pulse;
        logic              second_pulse;
        t_preload          preload_action;
    } t_result;

endpackage

`default_nettype wire

// ===== design/rtc_tick_with_drift_compensation_unit.sv =====
`default_nettype none

// Channel    Direction  tdata (low bit up)                         tuser
// s_axis     in         menu_load_value[7:0]                       menu_load_valid
// m_axis     out        preload_action[1:0], second_pulse,         none
//                       minute_pulse, hour_pulse, seconds_now[5:0],
//                       minutes_now[5:0], menu_remaining[7:0], zero pad
// cfg        in         drift_calibration[14:0], written when i_cfg_we is high
//
// One tick beat is accepted per cycle; its result appears in the output register
// on the next cycle. The clock state updates on the accepting edge, so the rate
// is set by that update loop. The input stalls only while the output
// register is full and the sink holds tready low. Synchronous active-low reset
// clears all counters, the drift error and the calibration register.
module rtc_tick_with_drift_compensation_unit #(
    parameter int TICKS_PER_SECOND = rtcdc_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [rtcdc_pkg::MENU_W-1:0]          i_s_axis_tdata,  // menu_load_value
    input  wire logic                                  i_s_axis_tuser,  // menu_load_valid
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // preload_action, second_pulse, minute_pulse, hour_pulse, seconds_now,
    // minutes_now, menu_remaining, zero pad
    output logic [rtcdc_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,
    input  wire logic                                  i_cfg_we,
    input  wire logic signed [rtcdc_pkg::CAL_W-1:0]    i_cfg_wdata      // drift_calibration
);
    import rtcdc_pkg::*;

    localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

    logic signed [CAL_W-1:0]   r_cal;
    logic [SUB_W-1:0]          r_sub,     n_sub;
    logic signed [DRIFT_W-1:0] r_drift,   n_drift;
    logic [TIME_W-1:0]         r_sec,     n_sec;
    logic [TIME_W-1:0]         r_min,     n_min;
    logic [MENU_W-1:0]         r_menu,    n_menu;
    logic                      r_out_valid;
    t_result                   r_out,     n_out;

    logic                      accept;
    logic                      sec_done;
    logic                      min_roll;
    logic [MENU_W-1:0]         menu_loaded;
    logic signed [DRIFT_W-1:0] drift_adj;
    logic signed [DRIFT_W:0]   drift_sum;
    t_preload                  action;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out);

    always_comb begin
        menu_loaded = i_s_axis_tuser ? i_s_axis_tdata : r_menu;

        if (r_drift > DRIFT_LIMIT_POS) begin
            action    = PRELOAD_RETARD;
            drift_adj = r_drift - DRIFT_STEP;
        end else if (r_drift < DRIFT_LIMIT_NEG) begin
            action    = PRELOAD_ADVANCE;
            drift_adj = r_drift + DRIFT_STEP;
        end else begin
            action    = PRELOAD_NONE;
            drift_adj = r_drift;
        end

        drift_sum = {drift_adj[DRIFT_W-1], drift_adj}
                  + {{(DRIFT_W+1-CAL_W){r_cal[CAL_W-1]}}, r_cal};

        sec_done = (r_sub == SUB_LAST);
        min_roll = sec_done && (r_sec == TIME_MAX);

        n_sub   = sec_done ? '0 : r_sub + 1'b1;
        n_drift = drift_adj;
        n_menu  = menu_loaded;
        n_sec   = r_sec;
        n_min   = r_min;

        if (sec_done) begin
            if (drift_sum > DRIFT_SAT_MAX) begin
                n_drift = DRIFT_SAT_MAX[DRIFT_W-1:0];
            end else if (drift_sum < DRIFT_SAT_MIN) begin
                n_drift = DRIFT_SAT_MIN[DRIFT_W-1:0];
            end else begin
                n_drift = drift_sum[DRIFT_W-1:0];
            end
            if (menu_loaded != '0) begin
                n_menu = menu_loaded - 1'b1;
            end
            if (min_roll) begin
                n_sec = '0;
                n_min = (r_min == TIME_MAX) ? '0 : r_min + 1'b1;
            end else begin
                n_sec = r_sec + 1'b1;
            end
        end

        n_out.preload_action = action;
        n_out.second_pulse   = sec_done;
        n_out.minute_pulse   = min_roll;
        n_out.hour_pulse     = min_roll && (r_min == TIME_MAX);
        n_out.seconds_now    = n_sec;
        n_out.minutes_now    = n_min;
        n_out.menu_remaining = n_menu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal       <= '0;
            r_sub       <= '0;
            r_drift     <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_menu      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cal <= i_cfg_wdata;
            end
            if (accept) begin
                r_sub   <= n_sub;
                r_drift <= n_drift;
                r_sec   <= n_sec;
                r_min   <= n_min;
                r_menu  <= n_menu;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    a_minute_has_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.minute_pulse |-> r_out.second_pulse)
        else $error("minute pulse without second pulse");

    a_hour_has_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.hour_pulse |-> r_out.minute_pulse && (r_min == '0))
        else $error("hour pulse without minute rollover");

    a_second_wraps_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && sec_done |=> r_sub == '0 && r_out.second_pulse)
        else $error("second completed but subsecond counter did not wrap");

    a_seconds_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.seconds_now <= TIME_MAX && r_out.minutes_now <= TIME_MAX)
        else $error("time field out of range");

endmodule

`default_nettype wire
